// ----- sv/msmooth_pkg.sv -----
// ----------------------------------------------------------------------------
// msmooth_pkg
// Shared types, constants and the sigmoid table of the mask smoothing block.
// ----------------------------------------------------------------------------
package msmooth_pkg;

	localparam int SIG_DEPTH = 1024;
	localparam int SIG_AW    = $clog2(SIG_DEPTH);

	// Uncertainty polynomial coefficients, Q20
	localparam logic signed [31:0] K1 = 32'sd5964741;
	localparam logic signed [31:0] K2 = -32'sd785068;
	localparam logic signed [31:0] K3 = -32'sd60613041;
	localparam logic signed [31:0] K4 = 32'sd305459626;
	localparam logic signed [31:0] K5 = -32'sd655063253;

	localparam logic [15:0] RATIO_RESET = 16'd45875;
	localparam logic [15:0] P_HALF      = 16'd32768;
	localparam logic [20:0] ONE_Q20     = 21'd1048576;
	localparam logic [63:0] EXP_STEP    = 64'd4292870656;
	localparam logic [63:0] ONE_Q32     = 64'h1_0000_0000;

	typedef enum logic {
		FUNC_MASK   = 1'b0,
		FUNC_NOMASK = 1'b1
	} func_t;

	// One pixel as it travels down the pipeline
	typedef struct packed {
		logic        hist;
		logic        last;
		logic [15:0] idx;
		logic [15:0] p;
	} pix_t;

	typedef logic [15:0] sig_rom_t [SIG_DEPTH];

	// e^(-k/2048) in Q32 by square and multiply
	function automatic logic [63:0] exp_neg_q32(input logic [15:0] k);
		logic [63:0]  acc;
		logic [63:0]  base;
		logic [127:0] tmp;
		acc  = ONE_Q32;
		base = EXP_STEP;
		for (int i = 0; i < 16; i++) begin
			if (k[i]) begin
				tmp = 128'(acc) * 128'(base) + 128'h8000_0000;
				acc = tmp[95:32];
			end
			tmp  = 128'(base) * 128'(base) + 128'h8000_0000;
			base = tmp[95:32];
		end
		return acc;
	endfunction

	// round(num / den) by restoring long division
	function automatic logic [63:0] div_round(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] n;
		logic [64:0] rem;
		logic [63:0] q;
		n   = num + (den >> 1);
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic sig_rom_t build_sigmoid();
		sig_rom_t    rom;
		int          mid;
		int          y;
		logic [15:0] k;
		logic [63:0] e;
		logic [63:0] num;
		logic [63:0] q;
		for (int b = 0; b < SIG_DEPTH; b++) begin
			mid = (2 * b + 1) << (15 - SIG_AW);
			y   = mid - 32768;
			k   = (y < 0) ? 16'(-y) : 16'(y);
			e   = exp_neg_q32(k);
			num = (y >= 0) ? 64'h1_0000_0000_0000 : (e << 16);
			q   = div_round(num, ONE_Q32 + e);
			rom[b] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sigmoid();

	// round(h * x / 2^24), half away from zero
	function automatic logic signed [31:0] mul_q24(input logic signed [31:0] h,
		input logic [22:0] x);
		logic [31:0] m;
		logic [54:0] pr;
		logic [30:0] r;
		m  = h[31] ? 32'(-h) : 32'(h);
		pr = 55'(m) * 55'(x) + 55'h80_0000;
		r  = pr[54:24];
		return h[31] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

endpackage

// ----- sv/msmooth_poly.sv -----
// ----------------------------------------------------------------------------
// msmooth_poly
// Squared distance from one half and the Horner chain of the uncertainty
// polynomial, one multiply per stage, giving the uncertainty in Q16.
// ----------------------------------------------------------------------------
module msmooth_poly (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_s1,
	input  msmooth_pkg::pix_t   pix_s1,
	output logic                vld_s8,
	output msmooth_pkg::pix_t   pix_s8,
	output logic [16:0]         u16_s8
);
	import msmooth_pkg::*;

	logic               vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	pix_t               pix_s2, pix_s3, pix_s4, pix_s5, pix_s6, pix_s7;
	logic [22:0]        x_s2, x_s3, x_s4, x_s5, x_s6;
	logic signed [31:0] h_s3, h_s4, h_s5, h_s6, poly_s7;

	logic signed [16:0] t;
	logic [15:0]        tm;
	logic [31:0]        sq;
	logic [20:0]        pc;
	logic [20:0]        unc;
	logic [20:0]        ur;

	always_comb begin
		t   = $signed({1'b0, pix_s1.p}) - $signed({1'b0, P_HALF});
		tm  = t[16] ? 16'(-t) : t[15:0];
		sq  = 32'(tm) * 32'(tm) + 32'd128;
		if (poly_s7 < 0) begin
			pc = '0;
		end else if (poly_s7 > $signed({11'd0, ONE_Q20})) begin
			pc = ONE_Q20;
		end else begin
			pc = poly_s7[20:0];
		end
		unc = ONE_Q20 - pc;
		ur  = unc + 21'd8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s2  <= pix_s1;
			x_s2    <= sq[30:8];
			pix_s3  <= pix_s2;
			x_s3    <= x_s2;
			h_s3    <= K4 + mul_q24(K5, x_s2);
			pix_s4  <= pix_s3;
			x_s4    <= x_s3;
			h_s4    <= K3 + mul_q24(h_s3, x_s3);
			pix_s5  <= pix_s4;
			x_s5    <= x_s4;
			h_s5    <= K2 + mul_q24(h_s4, x_s4);
			pix_s6  <= pix_s5;
			x_s6    <= x_s5;
			h_s6    <= K1 + mul_q24(h_s5, x_s5);
			pix_s7  <= pix_s6;
			poly_s7 <= mul_q24(h_s6, x_s6);
			pix_s8  <= pix_s7;
			u16_s8  <= ur[20:4];
		end
	end

	a_u16_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> (u16_s8 <= 17'd65536))
		else $error("uncertainty above one");

endmodule

// ----- sv/msmooth_store.sv -----
// ----------------------------------------------------------------------------
// msmooth_store
// Frame store read-modify-write: weight, blend toward the stored value when the
// pixel has history, write back and hold the result in the output register.
// ----------------------------------------------------------------------------
module msmooth_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_stall,
	output logic                en,
	input  logic                vld_s8,
	input  msmooth_pkg::pix_t   pix_s8,
	input  logic [16:0]         u16_s8,
	input  logic [15:0]         ratio,
	output logic                out_valid,
	output logic [15:0]         mask_value,
	output logic [15:0]         out_pixel_index,
	output logic                out_last
);
	import msmooth_pkg::*;

	logic               vld_s9, vld_s10, out_valid_q, fwd_q;
	pix_t               pix_s9, pix_s10;
	logic [32:0]        w_s9, w_s10;
	logic [15:0]        rd_q;
	logic [15:0]        val_q, idx_q;
	logic               last_q;
	logic [15:0]        mem [65536];

	logic [15:0]        prev;
	logic signed [16:0] d;
	logic [15:0]        mag;
	logic [48:0]        prod;
	logic [16:0]        adj;
	logic signed [17:0] sum;
	logic [15:0]        res;

	assign en              = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign mask_value      = val_q;
	assign out_pixel_index = idx_q;
	assign out_last        = last_q;

	always_comb begin
		// the entry may still be in flight from the pixel just ahead
		prev = fwd_q ? val_q : rd_q;
		d    = $signed({1'b0, prev}) - $signed({1'b0, pix_s10.p});
		mag  = d[16] ? 16'(-d) : d[15:0];
		prod = 49'(mag) * 49'(w_s10) + 49'h8000_0000;
		adj  = prod[48:32];
		sum  = d[16] ? $signed({2'b00, pix_s10.p}) - $signed({1'b0, adj})
		             : $signed({2'b00, pix_s10.p}) + $signed({1'b0, adj});
		if (!pix_s10.hist) begin
			res = pix_s10.p;
		end else if (sum < 0) begin
			res = '0;
		end else if (sum > 18'sd65535) begin
			res = 16'hFFFF;
		end else begin
			res = sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9      <= 1'b0;
			vld_s10     <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_q       <= 1'b0;
		end else if (en) begin
			vld_s9      <= vld_s8;
			vld_s10     <= vld_s9;
			out_valid_q <= vld_s10;
			fwd_q       <= vld_s10 && (pix_s10.idx == pix_s9.idx);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s9  <= pix_s8;
			w_s9    <= 33'(u16_s8) * 33'(ratio);
			pix_s10 <= pix_s9;
			w_s10   <= w_s9;
			rd_q    <= mem[pix_s9.idx];
			val_q   <= res;
			idx_q   <= pix_s10.idx;
			last_q  <= pix_s10.last;
			if (vld_s10) begin
				mem[pix_s10.idx] <= res;
			end
		end
	end

	a_fwd_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> out_valid_q)
		else $error("forward without a result in the output register");

	a_no_history_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s10 && !pix_s10.hist) |-> (res == pix_s10.p))
		else $error("pixel without history was blended");

	a_out_from_s10: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !vld_s10) |=> !out_valid_q)
		else $error("output register loaded from an empty stage");

endmodule

// ----- sv/segmentation_mask_temporal_smoothing_top.sv -----
// ----------------------------------------------------------------------------
// segmentation_mask_temporal_smoothing_top
// Temporal smoothing of a segmentation mask, one pixel per transaction.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one pixel: func, raw_logit,
// pixel_index, end_of_frame, pose_present. A transaction with func set marks
// a frame without mask: it clears the history and gives no result.
// Output channel (out_valid / out_stall) gives one result per mask pixel:
// mask_value, out_pixel_index, out_last.
// Throughput is one pixel per cycle unless out_stall holds. From the input
// transaction to out_valid: sigmoid ROM, seven polynomial stages, weight,
// frame store read and blend with write back into the output register.
// The frame store is a 64K x 16 single-port-write memory; a pixel that hits
// the entry being written by the pixel just ahead takes the forwarded value.
// cfg_we / cfg_data write combine_ratio; write it only while idle.
// Reset clears the history flag and all valid bits and loads combine_ratio
// with 0.7; the store itself is not cleared.
// When out_stall holds a waiting result, the whole pipeline holds and
// in_stall rises; it drops again the cycle the result is taken.
// ----------------------------------------------------------------------------
module segmentation_mask_temporal_smoothing_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] raw_logit,
	input  logic [15:0] pixel_index,
	input  logic        end_of_frame,
	input  logic        pose_present,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] mask_value,
	output logic [15:0] out_pixel_index,
	output logic        out_last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);
	import msmooth_pkg::*;

	logic              en;
	logic              in_acc;
	logic              nomask;
	logic              hist_q;
	logic [15:0]       ratio_q;
	logic [15:0]       code_ob;
	logic [SIG_AW-1:0] bin;
	logic              vld_s1, vld_s8;
	pix_t              pix_s1, pix_s8;
	logic [16:0]       u16_s8;

	assign in_stall = !en;
	assign in_acc   = in_valid && en;
	assign nomask   = (func_t'(func) == FUNC_NOMASK);
	assign code_ob  = raw_logit ^ 16'h8000;
	assign bin      = code_ob[15 -: SIG_AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
			hist_q  <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				ratio_q <= cfg_data;
			end
			if (in_acc) begin
				if (nomask) begin
					hist_q <= 1'b0;
				end else if (end_of_frame) begin
					hist_q <= pose_present;
				end
			end
			if (en) begin
				vld_s1 <= in_acc && !nomask;
			end
		end
	end

	// sigmoid ROM, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1.hist <= hist_q;
			pix_s1.last <= end_of_frame;
			pix_s1.idx  <= pixel_index;
			pix_s1.p    <= SIG_ROM[bin];
		end
	end

	msmooth_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_s1 (vld_s1),
		.pix_s1 (pix_s1),
		.vld_s8 (vld_s8),
		.pix_s8 (pix_s8),
		.u16_s8 (u16_s8)
	);

	msmooth_store u_store (
		.clk             (clk),
		.arst_n          (arst_n),
		.out_stall       (out_stall),
		.en              (en),
		.vld_s8          (vld_s8),
		.pix_s8          (pix_s8),
		.u16_s8          (u16_s8),
		.ratio           (ratio_q),
		.out_valid       (out_valid),
		.mask_value      (mask_value),
		.out_pixel_index (out_pixel_index),
		.out_last        (out_last)
	);

	a_nomask_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && nomask) |=> !hist_q)
		else $error("frame without mask left history valid");

endmodule
